FILE: sv/rdc_pkg.sv
package rdc_pkg;

    localparam int BASE_MIN = 2;
    localparam int BASE_MAX = 36;

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_ALPHA = 7'd55;

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  number_base;
    } t_in_item;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last_digit;
    } t_out_item;

    // digits 0-9 then A-Z; codes above 35 map to '0'
    function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
        logic [6:0] c;
        if (d < 6'd10) begin
            c = ASCII_ZERO + {1'b0, d};
        end else if (d < 6'(BASE_MAX)) begin
            c = ASCII_ALPHA + {1'b0, d};
        end else begin
            c = ASCII_ZERO;
        end
        return c;
    endfunction

endpackage

FILE: sv/rdc_ram.sv
module rdc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rdc_divider.sv
module rdc_divider #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [5:0]             i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [5:0]             o_remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_q;
    logic [5:0]             r_rem;

    logic [6:0] rem_sh;
    logic [6:0] rem_diff;
    logic       ge;

    // restoring step, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_q[VALUE_WIDTH-1]};
    assign ge       = rem_sh >= {1'b0, i_divisor};
    assign rem_diff = rem_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[VALUE_WIDTH-2:0], ge};
            r_rem <= ge ? rem_diff[5:0] : rem_sh[5:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

FILE: sv/radix_digit_converter_top.sv
// Each digit is produced by the shared bit-serial divider, through S_START and S_WAIT;
// each character is then read from the digit store in S_RD and loaded into the output
// register in S_LD, which holds while the output is stalled. A zero value gives one digit.
// One item at a time: the input is ready only when no conversion is in progress.
// Synchronous active-low reset clears the sequencer, counters and valid flags;
// the digit store is not cleared and needs no clearing pass.
module radix_digit_converter_top
    import rdc_pkg::*;
#(
    parameter int MAX_DIGITS  = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_LD    = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_quot, n_quot;
    logic [5:0]             r_base, n_base;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_ovalid, n_ovalid;
    t_out_item              r_odata, n_odata;

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [5:0]             div_rem;
    logic                   ram_we;
    logic [5:0]             ram_rdata;
    logic [CNT_W-1:0]       count_inc;
    logic [5:0]             base_clamped;

    rdc_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_quot),
        .i_divisor   (r_base),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    rdc_ram #(
        .WIDTH(6),
        .DEPTH(MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (div_rem),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign count_inc = r_count + 1'b1;

    always_comb begin
        if (i_in_data.number_base < 6'(BASE_MIN)) begin
            base_clamped = 6'(BASE_MIN);
        end else if (i_in_data.number_base > 6'(BASE_MAX)) begin
            base_clamped = 6'(BASE_MAX);
        end else begin
            base_clamped = i_in_data.number_base;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_quot    = r_quot;
        n_base    = r_base;
        n_count   = r_count;
        n_idx     = r_idx;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        div_start = 1'b0;
        ram_we    = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_quot  = i_in_data.value[VALUE_WIDTH-1:0];
                    n_base  = base_clamped;
                    n_count = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                div_start = 1'b1;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    // a zero value still runs one division and stores digit 0
                    ram_we  = 1'b1;
                    n_count = count_inc;
                    n_quot  = div_quot;
                    if (div_quot != '0 && count_inc != CNT_W'(MAX_DIGITS)) begin
                        n_state = S_START;
                    end else begin
                        n_idx   = r_count[IDX_W-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid           = 1'b1;
                    n_odata.digit_char = digit_to_ascii(ram_rdata);
                    n_odata.last_digit = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot  <= n_quot;
        r_base  <= n_base;
        r_idx   <= n_idx;
        r_odata <= n_odata;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
